// File: rtl/core/vflt_pkg.sv
`timescale 1ns / 1ps
package vflt_pkg;
    localparam int FRAME_BITS_DEF = 24;
    localparam int COUNT_BITS_DEF = 32;
    localparam int SEQ_W = 16;
    localparam int STAT_W = 32;
    localparam int NB_W = 4;
    localparam int GOP_W = 8;
    localparam int TOT_W = 24;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] REG_NB = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GOP = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TOT = 2'd2;

    localparam logic [1:0] KIND_I = 2'd0;
    localparam logic [1:0] KIND_IDR = 2'd1;
    localparam logic [1:0] KIND_P = 2'd2;
    localparam logic [1:0] KIND_B = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_REM,
        ST_DIV_B,
        ST_DIV_GOP,
        ST_UPDATE,
        ST_OUT
    } state_t;
endpackage

// File: rtl/core/video_frame_loss_tracker.sv
`timescale 1ns / 1ps
// sequence: three divides on one shared divider (DW is one more than the wider of FRAME_BITS
// and 24), then one update state; the result is then held until it is taken at the output
// packets: one at a time, the next input is taken only after the result has been transferred
// reset: asynchronous active low, counters cleared, tracking off, registers at defaults
module video_frame_loss_tracker #(
    parameter int FRAME_BITS = vflt_pkg::FRAME_BITS_DEF,
    parameter int COUNT_BITS = vflt_pkg::COUNT_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [vflt_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [vflt_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [vflt_pkg::SEQ_W-1:0]       seq_number,
    input  logic                             fragment_start,
    input  logic                             fragment_end,
    input  logic [FRAME_BITS-1:0]            frame_index,
    input  logic [1:0]                       picture_kind,
    input  logic                             warmup_over,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [vflt_pkg::STAT_W-1:0]      packets_received,
    output logic [vflt_pkg::STAT_W-1:0]      packets_lost,
    output logic [vflt_pkg::STAT_W-1:0]      frames_decoded,
    output logic [vflt_pkg::STAT_W-1:0]      frames_discarded,
    output logic                             tracking_active
);
    localparam int SW = FRAME_BITS + 2;
    localparam int DW = (FRAME_BITS > vflt_pkg::TOT_W) ? FRAME_BITS + 1 : vflt_pkg::TOT_W + 1;
    localparam int CW = $clog2(DW + 1);
    localparam int SQ = vflt_pkg::SEQ_W;
    localparam logic [COUNT_BITS-1:0] CMAX = '1;

    vflt_pkg::state_t state_reg, state_next;

    // configuration registers
    logic [vflt_pkg::NB_W-1:0]  nb_reg;
    logic [vflt_pkg::GOP_W-1:0] gop_reg;
    logic [vflt_pkg::TOT_W-1:0] tot_reg;

    // tracker state
    logic                  started_reg;
    logic [SQ-1:0]         last_seq_reg;
    logic signed [SW-1:0]  good_i_reg, good_p_reg, open_idx_reg, open_enc_reg;
    logic                  open_done_reg, open_drop_reg;
    logic [COUNT_BITS-1:0] cnt_reg [4];

    // captured packet
    logic [SQ-1:0]         seq_reg;
    logic                  fs_reg, fe_reg, warm_reg;
    logic [FRAME_BITS-1:0] frame_reg;
    logic [1:0]            kind_reg;

    // shared divider and its results
    logic [DW-1:0] dividend_reg, divisor_reg, quot_reg;
    logic [DW:0]   rem_reg;
    logic [CW-1:0] step_reg;
    logic          div_busy_reg;
    logic [DW-1:0] rem_res_reg, bq_res_reg, gop_rem_reg;
    logic          neg_reg;

    logic [DW:0]   trial;
    logic [DW:0]   shifted;
    logic          div_last;

    assign cfg_ready = (state_reg == vflt_pkg::ST_IDLE);
    assign in_ready  = (state_reg == vflt_pkg::ST_IDLE) && !cfg_valid;
    assign out_valid = (state_reg == vflt_pkg::ST_OUT);
    assign packets_received = vflt_pkg::STAT_W'(cnt_reg[0]);
    assign packets_lost     = vflt_pkg::STAT_W'(cnt_reg[1]);
    assign frames_decoded   = vflt_pkg::STAT_W'(cnt_reg[2]);
    assign frames_discarded = vflt_pkg::STAT_W'(cnt_reg[3]);
    assign tracking_active  = started_reg;

    // derived values from captured packet
    logic signed [SW-1:0] frame_s, nb_s, enc, enc1, nbp1_s, lastd, nextd, pref;
    logic signed [SW-1:0] rem_signed;
    assign frame_s = SW'(frame_reg);
    assign nb_s    = SW'(nb_reg);
    assign nbp1_s  = nb_s + SW'(1);
    assign enc1    = open_enc_reg + SW'(1);
    assign pref    = frame_s - nb_s - SW'(1);
    assign lastd   = SW'(bq_res_reg) * nbp1_s;
    assign nextd   = lastd + nbp1_s;

    always_comb
    begin
        priority if (kind_reg == vflt_pkg::KIND_B)
            enc = frame_s + SW'(1);
        else if (kind_reg == vflt_pkg::KIND_P)
            enc = frame_s - nb_s;
        else if (frame_reg == '0)
            enc = '0;
        else
            enc = frame_s - nb_s;
    end

    assign rem_signed = neg_reg ? -SW'(rem_res_reg) : SW'(rem_res_reg);

    // one restoring divide step
    assign shifted  = {rem_reg[DW-1:0], dividend_reg[DW-1]};
    assign trial    = shifted - {1'b0, divisor_reg};
    assign div_last = (step_reg == CW'(DW - 1));

    // divider operand for each phase
    logic [DW-1:0] op_a, op_b;
    always_comb
    begin
        unique case (state_reg)
            vflt_pkg::ST_DIV_B:
            begin
                op_a = DW'(frame_reg);
                op_b = DW'(nbp1_s);
            end
            vflt_pkg::ST_DIV_GOP:
            begin
                op_a = DW'(nextd);
                op_b = DW'(gop_reg);
            end
            default:
            begin
                op_a = enc1[SW-1] ? DW'(-enc1) : DW'(enc1);
                op_b = DW'(tot_reg);
            end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            vflt_pkg::ST_IDLE:
                if (in_valid && in_ready) state_next = vflt_pkg::ST_DIV_REM;
            vflt_pkg::ST_DIV_REM:
                if (div_busy_reg && div_last) state_next = vflt_pkg::ST_DIV_B;
            vflt_pkg::ST_DIV_B:
                if (div_busy_reg && div_last) state_next = vflt_pkg::ST_DIV_GOP;
            vflt_pkg::ST_DIV_GOP:
                if (div_busy_reg && div_last) state_next = vflt_pkg::ST_UPDATE;
            vflt_pkg::ST_UPDATE:
                state_next = vflt_pkg::ST_OUT;
            vflt_pkg::ST_OUT:
                if (out_ready) state_next = vflt_pkg::ST_IDLE;
            default:
                state_next = vflt_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= vflt_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nb_reg  <= vflt_pkg::NB_W'(2);
            gop_reg <= vflt_pkg::GOP_W'(12);
            tot_reg <= '1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == vflt_pkg::REG_NB) nb_reg <= cfg_data[vflt_pkg::NB_W-1:0];
            if (cfg_index == vflt_pkg::REG_GOP) gop_reg <= cfg_data[vflt_pkg::GOP_W-1:0];
            if (cfg_index == vflt_pkg::REG_TOT) tot_reg <= cfg_data[vflt_pkg::TOT_W-1:0];
        end
    end

    // packet capture
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            seq_reg   <= seq_number;
            fs_reg    <= fragment_start;
            fe_reg    <= fragment_end;
            frame_reg <= frame_index;
            kind_reg  <= picture_kind;
            warm_reg  <= warmup_over;
        end
    end

    // shared divider, one quotient bit per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_busy_reg <= 1'b0;
            step_reg     <= '0;
        end
        else if (state_reg == vflt_pkg::ST_DIV_REM || state_reg == vflt_pkg::ST_DIV_B
                 || state_reg == vflt_pkg::ST_DIV_GOP)
        begin
            if (!div_busy_reg)
            begin
                div_busy_reg <= 1'b1;
                step_reg     <= '0;
                dividend_reg <= op_a;
                divisor_reg  <= op_b;
                rem_reg      <= '0;
                quot_reg     <= '0;
            end
            else
            begin
                dividend_reg <= {dividend_reg[DW-2:0], 1'b0};
                if (!trial[DW])
                begin
                    rem_reg  <= trial;
                    quot_reg <= {quot_reg[DW-2:0], 1'b1};
                end
                else
                begin
                    rem_reg  <= shifted;
                    quot_reg <= {quot_reg[DW-2:0], 1'b0};
                end
                step_reg <= step_reg + CW'(1);
                if (div_last)
                begin
                    div_busy_reg <= 1'b0;
                    unique case (state_reg)
                        vflt_pkg::ST_DIV_REM:
                        begin
                            rem_res_reg <= (tot_reg == '0) ? op_a
                                         : (!trial[DW] ? trial[DW-1:0] : shifted[DW-1:0]);
                            neg_reg     <= enc1[SW-1];
                        end
                        vflt_pkg::ST_DIV_B:
                            bq_res_reg <= {quot_reg[DW-2:0], !trial[DW]};
                        default:
                            gop_rem_reg <= !trial[DW] ? trial[DW-1:0] : shifted[DW-1:0];
                    endcase
                end
            end
        end
    end

    // tracker update
    logic [SQ-1:0]         seq_inc;
    logic [COUNT_BITS-1:0] pk_lost, fr_add;
    logic signed [SW:0]    fr_lost;
    logic                  pass, gop_hit;
    logic signed [SW-1:0]  rem_cmp;
    logic                  gap, drop_now;

    assign seq_inc  = last_seq_reg + SQ'(1);
    assign gop_hit  = (gop_reg != '0) && (gop_rem_reg == '0);
    assign rem_cmp  = (tot_reg == '0) ? enc1 : rem_signed;
    assign gap      = (seq_reg != seq_inc);
    // a gap inside a frame marks it for discard before its closing fragment is judged
    assign drop_now = open_drop_reg || (gap && !fs_reg);

    always_comb
    begin
        pk_lost = '0;
        fr_lost = '0;
        if (gap)
        begin
            pk_lost = (seq_reg > last_seq_reg) ? COUNT_BITS'(seq_reg - last_seq_reg)
                                               : COUNT_BITS'(1);
            // encoding number not ahead of the open frame gives minus one
            if (enc > rem_cmp)
                fr_lost = (enc > open_enc_reg) ? (SW + 1)'(enc - open_enc_reg - SW'(1)) : '1;
            if (!open_done_reg) fr_lost = fr_lost + (SW + 1)'(1);
        end
        if (kind_reg == vflt_pkg::KIND_I || kind_reg == vflt_pkg::KIND_IDR)
            pass = 1'b1;
        else if (kind_reg == vflt_pkg::KIND_P)
            pass = (good_i_reg == pref) || (good_p_reg == pref);
        else if (gop_hit)
            pass = (good_p_reg == lastd) && (good_i_reg == nextd);
        else
            pass = (good_p_reg == nextd);
        if (fs_reg && !pass && fe_reg) fr_lost = fr_lost + (SW + 1)'(1);
        if (!fs_reg && fe_reg && drop_now) fr_lost = fr_lost + (SW + 1)'(1);
        fr_add = fr_lost[SW] ? '0 : COUNT_BITS'(fr_lost);
    end

    function automatic logic [COUNT_BITS-1:0] sat(input logic [COUNT_BITS-1:0] c,
                                                   input logic [COUNT_BITS-1:0] v);
        logic [COUNT_BITS:0] s;
        s = {1'b0, c} + {1'b0, v};
        return s[COUNT_BITS] ? CMAX : s[COUNT_BITS-1:0];
    endfunction

    logic is_ref;
    assign is_ref = (kind_reg == vflt_pkg::KIND_I || kind_reg == vflt_pkg::KIND_IDR);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            started_reg   <= 1'b0;
            last_seq_reg  <= '0;
            good_i_reg    <= '1;
            good_p_reg    <= '1;
            open_idx_reg  <= '0;
            open_enc_reg  <= '0;
            open_done_reg <= 1'b1;
            open_drop_reg <= 1'b0;
            for (int k = 0; k < 4; k++) cnt_reg[k] <= '0;
        end
        else if (state_reg == vflt_pkg::ST_UPDATE)
        begin
            if (!started_reg)
            begin
                if (warm_reg && is_ref && fs_reg)
                begin
                    last_seq_reg <= seq_reg;
                    good_p_reg   <= (frame_reg != '0) ? pref : '1;
                    open_idx_reg <= frame_s;
                    open_enc_reg <= enc;
                    if (fe_reg)
                    begin
                        open_done_reg <= 1'b1;
                        good_i_reg    <= frame_s;
                        cnt_reg[2]    <= sat(cnt_reg[2], COUNT_BITS'(1));
                    end
                    else
                    begin
                        open_drop_reg <= 1'b0;
                        open_done_reg <= 1'b0;
                        good_i_reg    <= '1;
                    end
                    cnt_reg[0]  <= sat(cnt_reg[0], COUNT_BITS'(1));
                    started_reg <= 1'b1;
                end
            end
            else
            begin
                last_seq_reg <= seq_reg;
                if (gap && !fs_reg) open_drop_reg <= 1'b1;
                if (fs_reg)
                begin
                    if (pass)
                    begin
                        if (fe_reg)
                        begin
                            if (kind_reg == vflt_pkg::KIND_P) open_drop_reg <= 1'b0;
                            open_done_reg <= 1'b1;
                            if (is_ref) good_i_reg <= frame_s;
                            else if (kind_reg == vflt_pkg::KIND_P) good_p_reg <= frame_s;
                            cnt_reg[2] <= sat(cnt_reg[2], COUNT_BITS'(1));
                        end
                        else
                        begin
                            open_drop_reg <= 1'b0;
                            open_done_reg <= 1'b0;
                        end
                    end
                    else
                    begin
                        open_drop_reg <= 1'b1;
                        open_done_reg <= fe_reg;
                    end
                    open_idx_reg <= frame_s;
                    open_enc_reg <= enc;
                end
                else if (fe_reg)
                begin
                    if (!drop_now)
                    begin
                        if (is_ref) good_i_reg <= open_idx_reg;
                        else if (kind_reg == vflt_pkg::KIND_P) good_p_reg <= open_idx_reg;
                        cnt_reg[2] <= sat(cnt_reg[2], COUNT_BITS'(1));
                    end
                    open_done_reg <= 1'b1;
                end
                cnt_reg[0] <= sat(cnt_reg[0], COUNT_BITS'(1));
                cnt_reg[1] <= sat(cnt_reg[1], pk_lost);
                cnt_reg[3] <= sat(cnt_reg[3], fr_add);
            end
        end
    end
endmodule

// File: tb/vflt_checker.sv
`timescale 1ns / 1ps
module vflt_checker (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_valid,
    input  logic                                  cfg_ready,
    input  logic [vflt_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [vflt_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic                                  in_valid,
    input  logic                                  in_ready,
    input  logic [vflt_pkg::SEQ_W-1:0]            seq_number,
    input  logic                                  fragment_start,
    input  logic                                  fragment_end,
    input  logic [vflt_pkg::FRAME_BITS_DEF-1:0]   frame_index,
    input  logic [1:0]                            picture_kind,
    input  logic                                  warmup_over,
    input  logic                                  out_valid,
    input  logic                                  out_ready,
    input  logic [vflt_pkg::STAT_W-1:0]           packets_received,
    input  logic [vflt_pkg::STAT_W-1:0]           packets_lost,
    input  logic [vflt_pkg::STAT_W-1:0]           frames_decoded,
    input  logic [vflt_pkg::STAT_W-1:0]           frames_discarded,
    input  logic                                  tracking_active,
    output int                                    errors,
    output int                                    pending,
    output int                                    results_seen
);
    typedef struct {
        logic [vflt_pkg::STAT_W-1:0] rx;
        logic [vflt_pkg::STAT_W-1:0] lost;
        logic [vflt_pkg::STAT_W-1:0] dec;
        logic [vflt_pkg::STAT_W-1:0] disc;
        logic                        act;
    } stats_t;

    stats_t expected_stats[$];

    // shadow configuration
    logic [vflt_pkg::NB_W-1:0]  nb_cfg;
    logic [vflt_pkg::GOP_W-1:0] gop_cfg;
    logic [vflt_pkg::TOT_W-1:0] tot_cfg;

    // shadow tracker state
    bit                           started;
    logic [vflt_pkg::SEQ_W-1:0]   prev_seq;
    longint                       good_i;
    longint                       good_p;
    longint                       cur_frame;
    longint                       cur_enc;
    bit                           cur_done;
    bit                           cur_drop;
    longint unsigned              cnt[4];

    function automatic longint unsigned sat32(longint unsigned c, longint unsigned v);
        longint unsigned cmax;
        cmax = 64'hFFFF_FFFF;
        if (v > cmax - c) return cmax;
        return c + v;
    endfunction

    function automatic longint wrap_rem(longint a, longint m);
        if (m <= 0) return a;
        if (a >= 0) return a % m;
        return -((-a) % m);
    endfunction

    // advance the shadow tracker by one packet and return the counters it reports
    task automatic track_packet(output stats_t res);
        longint nb;
        longint fr;
        longint enc;
        longint fr_lost;
        longint unsigned pk_lost;
        longint refn;
        longint lastd;
        longint nextd;
        bit ok;
        nb = longint'(nb_cfg);
        fr = longint'(frame_index);
        if (picture_kind == vflt_pkg::KIND_B) enc = fr + 1;
        else if (picture_kind == vflt_pkg::KIND_P) enc = fr - nb;
        else enc = (fr == 0) ? 0 : fr - nb;

        if (!started) begin
            if (warmup_over && picture_kind != vflt_pkg::KIND_P
                && picture_kind != vflt_pkg::KIND_B && fragment_start) begin
                prev_seq = seq_number;
                good_p = (fr > 0) ? fr - nb - 1 : -1;
                cur_frame = fr;
                cur_enc = enc;
                if (fragment_end) begin
                    cur_done = 1;
                    good_i = fr;
                    cnt[2] = sat32(cnt[2], 1);
                end else begin
                    cur_drop = 0;
                    cur_done = 0;
                    good_i = -1;
                end
                cnt[0] = sat32(cnt[0], 1);
                started = 1;
            end
        end else begin
            pk_lost = 0;
            fr_lost = 0;
            // sequence gap handling
            if (seq_number != vflt_pkg::SEQ_W'(prev_seq + 1)) begin
                pk_lost = (seq_number > prev_seq ? longint'(seq_number)
                           : longint'(prev_seq) + 1) - longint'(prev_seq);
                if (enc > wrap_rem(cur_enc + 1, longint'(tot_cfg)))
                    fr_lost = (enc > cur_enc ? enc : cur_enc) - cur_enc - 1;
                if (!cur_done) fr_lost++;
                if (!fragment_start) cur_drop = 1;
            end
            prev_seq = seq_number;

            if (fragment_start) begin
                // dependency check on the new frame
                if (picture_kind == vflt_pkg::KIND_I || picture_kind == vflt_pkg::KIND_IDR) begin
                    ok = 1;
                end else if (picture_kind == vflt_pkg::KIND_P) begin
                    refn = fr - nb - 1;
                    ok = (good_i == refn) || (good_p == refn);
                end else begin
                    lastd = (fr / (nb + 1)) * (nb + 1);
                    nextd = lastd + nb + 1;
                    if (gop_cfg != 0 && nextd % longint'(gop_cfg) == 0)
                        ok = (good_p == lastd) && (good_i == nextd);
                    else
                        ok = (good_p == nextd);
                end
                if (ok) begin
                    if (picture_kind == vflt_pkg::KIND_P) cur_drop = 0;
                    if (fragment_end) begin
                        cur_done = 1;
                        if (picture_kind == vflt_pkg::KIND_I
                            || picture_kind == vflt_pkg::KIND_IDR) good_i = fr;
                        else if (picture_kind == vflt_pkg::KIND_P) good_p = fr;
                        cnt[2] = sat32(cnt[2], 1);
                    end else begin
                        cur_drop = 0;
                        cur_done = 0;
                    end
                end else begin
                    cur_drop = 1;
                    cur_done = fragment_end;
                    if (fragment_end) fr_lost++;
                end
                cur_frame = fr;
                cur_enc = enc;
            end else if (fragment_end) begin
                // closing fragment of the open frame
                if (!cur_drop) begin
                    if (picture_kind == vflt_pkg::KIND_I
                        || picture_kind == vflt_pkg::KIND_IDR) good_i = cur_frame;
                    else if (picture_kind == vflt_pkg::KIND_P) good_p = cur_frame;
                    cnt[2] = sat32(cnt[2], 1);
                end else begin
                    fr_lost++;
                end
                cur_done = 1;
            end

            cnt[0] = sat32(cnt[0], 1);
            cnt[1] = sat32(cnt[1], pk_lost);
            cnt[3] = sat32(cnt[3], fr_lost > 0 ? longint'(fr_lost) : 0);
        end
        res.rx = cnt[0][31:0];
        res.lost = cnt[1][31:0];
        res.dec = cnt[2][31:0];
        res.disc = cnt[3][31:0];
        res.act = started;
    endtask

    task automatic compare_field(string name, logic [vflt_pkg::STAT_W-1:0] exp_v,
                                 logic [vflt_pkg::STAT_W-1:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t mismatch %s: expected %0d actual %0d", $realtime, name, exp_v, act_v);
            errors++;
        end
    endtask

    // watch the three channels
    always @(posedge clk or negedge rst_n) begin
        stats_t s;
        stats_t e;
        if (!rst_n) begin
            nb_cfg = 4'd2;
            gop_cfg = 8'd12;
            tot_cfg = 24'hFFFFFF;
            started = 0;
            prev_seq = '0;
            good_i = -1;
            good_p = -1;
            cur_frame = 0;
            cur_enc = 0;
            cur_done = 1;
            cur_drop = 0;
            foreach (cnt[i]) cnt[i] = 0;
            expected_stats.delete();
            errors = 0;
            results_seen = 0;
            pending = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    vflt_pkg::REG_NB:  nb_cfg = cfg_data[vflt_pkg::NB_W-1:0];
                    vflt_pkg::REG_GOP: gop_cfg = cfg_data[vflt_pkg::GOP_W-1:0];
                    vflt_pkg::REG_TOT: tot_cfg = cfg_data[vflt_pkg::TOT_W-1:0];
                    default: ;
                endcase
            end
            if (in_valid && in_ready) begin
                track_packet(s);
                expected_stats.insert(expected_stats.size(), s);
            end
            if (out_valid && out_ready) begin
                results_seen++;
                if (expected_stats.size() == 0) begin
                    $display("%0t unexpected result transfer: expected none actual %0d",
                             $realtime, packets_received);
                    errors++;
                end else begin
                    e = expected_stats.pop_front();
                    compare_field("packets_received", e.rx, packets_received);
                    compare_field("packets_lost", e.lost, packets_lost);
                    compare_field("frames_decoded", e.dec, frames_decoded);
                    compare_field("frames_discarded", e.disc, frames_discarded);
                    compare_field("tracking_active", 32'(e.act), 32'(tracking_active));
                end
            end
            pending = expected_stats.size();
        end
    end
endmodule

// File: tb/video_frame_loss_tracker_tb.sv
`timescale 1ns / 1ps
module video_frame_loss_tracker_tb;
    localparam int FB = vflt_pkg::FRAME_BITS_DEF;
    localparam int SQW = vflt_pkg::SEQ_W;
    localparam int CDW = vflt_pkg::CFG_DATA_W;
    localparam int IDLE_LIMIT = 20000;
    localparam int SETTLE = 120;

    logic                            clk;
    logic                            rst_n;
    logic                            cfg_valid;
    logic                            cfg_ready;
    logic [vflt_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [CDW-1:0]                  cfg_data;
    logic                            in_valid;
    logic                            in_ready;
    logic [SQW-1:0]                  seq_number;
    logic                            fragment_start;
    logic                            fragment_end;
    logic [FB-1:0]                   frame_index;
    logic [1:0]                      picture_kind;
    logic                            warmup_over;
    logic                            out_valid;
    logic                            out_ready;
    logic [vflt_pkg::STAT_W-1:0]     packets_received;
    logic [vflt_pkg::STAT_W-1:0]     packets_lost;
    logic [vflt_pkg::STAT_W-1:0]     frames_decoded;
    logic [vflt_pkg::STAT_W-1:0]     frames_discarded;
    logic                            tracking_active;

    int errors;
    int pending;
    int results_seen;
    int packets_sent;
    int tx_gap_max;
    int rx_gap_max;
    bit rx_long_hold;
    int idle_cycles;
    logic [SQW-1:0] next_seq;

    video_frame_loss_tracker dut (.*);

    vflt_checker checker_i (.*);

    initial begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // transfer of one packet
    task automatic send_packet(logic [SQW-1:0] s, bit fs, bit fe, logic [FB-1:0] fr,
                               logic [1:0] k, bit w);
        int gap;
        gap = $urandom_range(tx_gap_max, 0);
        if (gap > 0) begin
            in_valid <= 0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1;
        seq_number <= s;
        fragment_start <= fs;
        fragment_end <= fe;
        frame_index <= fr;
        picture_kind <= k;
        warmup_over <= w;
        do @(negedge clk); while (!in_ready);
        @(posedge clk);
        packets_sent++;
    endtask

    task automatic write_reg(logic [vflt_pkg::CFG_IDX_W-1:0] idx, logic [CDW-1:0] val);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(negedge clk); while (!cfg_ready);
        @(posedge clk);
        cfg_valid <= 0;
    endtask

    // drain, let the divider settle, then reprogram all registers
    task automatic new_setting(int nb, int gop, int tot);
        in_valid <= 0;
        while (pending != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        write_reg(vflt_pkg::REG_NB, CDW'(nb));
        write_reg(vflt_pkg::REG_GOP, CDW'(gop));
        write_reg(vflt_pkg::REG_TOT, CDW'(tot));
    endtask

    // one frame split into fragments, with occasional packet loss
    task automatic send_frame(int fr, logic [1:0] k);
        int n;
        n = $urandom_range(3, 1);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(99, 0) < 4) next_seq += SQW'($urandom_range(4, 1));
            if ($urandom_range(99, 0) < 3 && n > 1) continue;
            send_packet(next_seq, i == 0, i == n - 1, FB'(fr), k, 1);
            next_seq++;
        end
    endtask

    // stream in decode order: reference frame, then the b frames before it
    task automatic send_stream(int nb, int gop, int quota, int base);
        int r;
        int stop;
        logic [1:0] k;
        r = base;
        stop = packets_sent + quota;
        while (packets_sent < stop) begin
            if (gop != 0 && r % gop == 0)
                k = ($urandom_range(1, 0) != 0) ? vflt_pkg::KIND_IDR : vflt_pkg::KIND_I;
            else k = vflt_pkg::KIND_P;
            if ($urandom_range(99, 0) >= 3) send_frame(r, k);
            for (int b = r - nb; b < r; b++)
                if (b >= 0 && $urandom_range(99, 0) >= 3) send_frame(b, vflt_pkg::KIND_B);
            // noise packet
            if ($urandom_range(99, 0) < 6) begin
                send_packet(SQW'($urandom), $urandom_range(1, 0), $urandom_range(1, 0),
                            FB'($urandom), 2'($urandom), $urandom_range(1, 0));
            end
            r += nb + 1;
        end
    endtask

    // result side stalls
    initial begin
        int n;
        out_ready = 0;
        @(posedge rst_n);
        forever begin
            if (rx_long_hold) begin
                n = 400;
                rx_long_hold = 0;
            end else begin
                n = $urandom_range(rx_gap_max, 0);
            end
            if (n > 0) begin
                out_ready <= 0;
                repeat (n) @(posedge clk);
            end
            out_ready <= 1;
            do @(negedge clk); while (!out_valid);
            @(posedge clk);
        end
    end

    // watchdog on transfer activity
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("video_frame_loss_tracker_tb failed");
            $finish;
        end
    end

    initial begin
        rst_n = 0;
        cfg_valid = 0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 0;
        seq_number = '0;
        fragment_start = 0;
        fragment_end = 0;
        frame_index = '0;
        picture_kind = vflt_pkg::KIND_I;
        warmup_over = 0;
        packets_sent = 0;
        tx_gap_max = 14;
        rx_gap_max = 14;
        rx_long_hold = 0;
        idle_cycles = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: ignored packets before tracking starts
        send_packet(16'd7, 1, 1, 24'd0, vflt_pkg::KIND_IDR, 0);
        send_packet(16'd8, 1, 1, 24'd3, vflt_pkg::KIND_P, 1);
        send_packet(16'd9, 1, 1, 24'd1, vflt_pkg::KIND_B, 1);
        // tracking starts on a fragmented i frame
        send_packet(16'd100, 1, 0, 24'd0, vflt_pkg::KIND_I, 1);
        send_packet(16'd101, 0, 0, 24'd0, vflt_pkg::KIND_I, 1);
        send_packet(16'd102, 0, 1, 24'd0, vflt_pkg::KIND_I, 1);
        send_packet(16'd103, 1, 1, 24'd3, vflt_pkg::KIND_P, 1);
        send_packet(16'd104, 1, 1, 24'd1, vflt_pkg::KIND_B, 1);
        send_packet(16'd105, 1, 1, 24'd2, vflt_pkg::KIND_B, 1);
        // sequence going backwards
        send_packet(16'd50, 1, 1, 24'd6, vflt_pkg::KIND_P, 1);
        // sequence wrap and large jumps
        send_packet(16'hFFFF, 1, 1, 24'd4, vflt_pkg::KIND_B, 0);
        send_packet(16'h0000, 1, 1, 24'd5, vflt_pkg::KIND_B, 1);
        send_packet(16'h8000, 1, 0, 24'hFFFFFF, vflt_pkg::KIND_B, 1);
        send_packet(16'h8001, 0, 1, 24'hFFFFFF, vflt_pkg::KIND_B, 1);
        // negative encoding number, then a gap behind it
        send_packet(16'h8002, 1, 1, 24'd0, vflt_pkg::KIND_P, 1);
        send_packet(16'h8006, 1, 1, 24'd12, vflt_pkg::KIND_IDR, 1);
        send_packet(16'h8008, 0, 1, 24'd12, vflt_pkg::KIND_IDR, 1);
        send_packet(16'h8009, 1, 0, 24'd15, vflt_pkg::KIND_P, 1);
        send_packet(16'h800B, 0, 1, 24'd15, vflt_pkg::KIND_P, 1);
        next_seq = 16'hFFF0;

        // default setting, with one long result stall
        rx_long_hold = 1;
        send_stream(2, 12, 250, 0);
        // single reference layout, nb of zero, gop and trace total of one, no idling
        tx_gap_max = 0;
        rx_gap_max = 0;
        new_setting(0, 1, 1);
        send_stream(0, 1, 250, 0);
        // largest registers
        tx_gap_max = 14;
        rx_gap_max = 14;
        new_setting(15, 255, 24'hFFFFFF);
        send_stream(15, 240, 250, 0);
        // zero gop and zero trace total
        new_setting(3, 0, 0);
        send_stream(3, 0, 250, 0);
        // short trace so encoding numbers wrap
        tx_gap_max = 3;
        rx_gap_max = 0;
        new_setting(1, 8, 50);
        send_stream(1, 8, 250, 0);
        // random trace total at high frame numbers
        tx_gap_max = 14;
        rx_gap_max = 14;
        new_setting(2, 12, $urandom_range(24'hFFFFFF, 1));
        send_stream(2, 12, 300, 16777200 - (16777200 % 12));

        in_valid <= 0;
        while (pending != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        $display("covered %0d packets over six register settings, %0d results checked",
                 packets_sent, results_seen);
        $display("final counters: %0d received, %0d decoded, %0d discarded",
                 packets_received, frames_decoded, frames_discarded);
        if (errors == 0)
            $display("video_frame_loss_tracker_tb passed");
        else
            $display("video_frame_loss_tracker_tb failed");
        $finish;
    end
endmodule
